// File: sv/hsc_pkg.sv
`timescale 1ns / 1ps
package hsc_pkg;

  localparam int NUM_SYMBOLS_DEF   = 256;
  localparam int MAX_CODE_LEN_DEF  = 16;
  localparam int DECODER_NODES_DEF = 1024;

  localparam int FUNC_W = 3;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 5;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int ERR_W  = 2;
  localparam int FILL_W = 4;
  localparam int SL_W   = 4;
  localparam int BIDX_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 3'd0,
    FN_BUILD  = 3'd1,
    FN_ENCODE = 3'd2,
    FN_DECODE = 3'd3,
    FN_FLUSH  = 3'd4
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE = 2'd0,
    KIND_SYM  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNCODED  = 2'd1,
    ERR_NO_DEC   = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] value;
    err_t              err;
  } result_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_CMD,
    S_SCAN,
    S_SCAN_END,
    S_BPREP,
    S_ASG_RD,
    S_ASG_EV,
    S_ASG_NXT,
    S_INS_RD,
    S_INS_EV,
    S_BDONE,
    S_ENC_CHK,
    S_ENC_BIT,
    S_DEC_BIT,
    S_DEC_CHK,
    S_FIN
  } state_t;

endpackage

// File: sv/hsc_in_if.sv
`timescale 1ns / 1ps
interface hsc_in_if;
  import hsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SYM_W-1:0]  symbol;
  logic [LEN_W-1:0]  code_length;
  logic [BYTE_W-1:0] data_byte;
  logic              last_in;

  modport source(output valid, func, symbol, code_length, data_byte, last_in, input ready);
  modport sink(input valid, func, symbol, code_length, data_byte, last_in, output ready);
endinterface

// File: sv/hsc_out_if.sv
`timescale 1ns / 1ps
interface hsc_out_if;
  import hsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_value;
  logic [ERR_W-1:0]  error_code;
  logic              last;

  modport source(output valid, out_kind, out_value, error_code, last, input ready);
  modport sink(input valid, out_kind, out_value, error_code, last, output ready);
endinterface

// File: sv/hsc_ram.sv
`timescale 1ns / 1ps
module hsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// File: sv/huffman_stream_codec.sv
// Canonical Huffman byte codec.
// The input channel in_ch carries one command per transfer: load a code
// length, build the tables, encode a symbol, decode a coded byte or flush
// the open byte. The result channel out_ch carries coded bytes, decoded
// symbols and error reports; the final result of a command has last set.
// A new command is taken only after all results of the previous one have
// moved into the output register, so the receiver may stall freely.
// Encode reads the length and code memories, then shifts out one code
// bit per cycle unless the output stalls. Decode shifts in one prefix bit
// per cycle; each bit that reads the node memory passes through S_DEC_BIT
// and S_DEC_CHK, which waits while the output stalls.
// Build clears the node and code memories, scans the lengths, then for
// every length from the longest down to the shortest takes each symbol
// through S_ASG_RD, S_ASG_EV and S_ASG_NXT, and inserts each code through
// S_INS_RD and S_INS_EV for every node visited. After reset, a clearing
// pass zeroes all three memories before the first command is taken.
`timescale 1ns / 1ps
module huffman_stream_codec #(
  parameter int NUM_SYMBOLS   = hsc_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN  = hsc_pkg::MAX_CODE_LEN_DEF,
  parameter int DECODER_NODES = hsc_pkg::DECODER_NODES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  hsc_in_if.sink    in_ch,
  hsc_out_if.source out_ch
);
  import hsc_pkg::*;

  localparam int NA     = $clog2(DECODER_NODES);
  localparam int SA     = $clog2(NUM_SYMBOLS);
  localparam int NODE_W = 2 * NA + SYM_W;
  localparam int CUR_W  = NA + 1;

  state_t state_r, state_nxt;

  logic [FUNC_W-1:0] func_r;
  logic [SYM_W-1:0]  sym_r;
  logic [LEN_W-1:0]  clen_r;
  logic [BYTE_W-1:0] dbyte_r;

  logic [NA-1:0]     cnt_r, cnt_nxt;
  logic              clr_len_r, clr_len_nxt;
  logic [SL_W-1:0]   sl_r, sl_nxt;
  logic [LEN_W-1:0]  mn_r, mn_nxt, mx_r, mx_nxt;
  logic              dec_ok_r, dec_ok_nxt;
  logic [LEN_W-1:0]  len_cur_r, len_cur_nxt;
  logic [7:0]        bits_r, bits_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [NA-1:0]     ins_pos_r, ins_pos_nxt;
  logic [LEN_W-1:0]  ins_rem_r, ins_rem_nxt;
  logic [7:0]        ins_b_r, ins_b_nxt;
  logic [SYM_W-1:0]  ins_sym_r, ins_sym_nxt;
  logic              scan_v_r, scan_v_nxt;
  logic [LEN_W-1:0]  enc_j_r, enc_j_nxt;
  logic [7:0]        enc_code_r, enc_code_nxt;
  logic [7:0]        cache_r, cache_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [BIDX_W-1:0] dec_i_r, dec_i_nxt;
  logic [7:0]        pa_r, pa_nxt;
  logic [SL_W-1:0]   pc_r, pc_nxt;
  logic              walking_r, walking_nxt;
  logic [NA-1:0]     cur_c0_r, cur_c0_nxt, cur_c1_r, cur_c1_nxt;
  logic              pend_v_r, pend_v_nxt;
  result_t           pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt;
  result_t           out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  logic              len_we, len_re;
  logic [SA-1:0]     len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata, len_rdata;
  logic              code_we, code_re;
  logic [SA-1:0]     code_waddr, code_raddr;
  logic [7:0]        code_wdata, code_rdata;
  logic              node_we, node_re;
  logic [NA-1:0]     node_waddr, node_raddr;
  logic [NODE_W-1:0] node_wdata, node_rdata;

  logic [NA-1:0]     rd_c0, rd_c1;
  logic [SYM_W-1:0]  rd_sym;

  logic              emit_req, can_emit, stall, out_free;
  result_t           emit_res;

  logic              sym_ok, len_ok, last_sym, asg_match, cursor_full;
  logic              enc_bit, ins_t, dec_bit, prefix_more;
  logic [7:0]        cache_shift, flush_val, len_mask, sl_mask, asg_b, asg_prefix, pa_new;
  logic [FILL_W-1:0] fill_inc;
  logic [SL_W-1:0]   pc_inc;
  logic [LEN_W-1:0]  rem_total, rem_m1;
  logic [NA-1:0]     ins_child;

  hsc_ram #(.WIDTH(LEN_W), .DEPTH(NUM_SYMBOLS)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .re(len_re), .raddr(len_raddr), .rdata_r(len_rdata)
  );

  hsc_ram #(.WIDTH(8), .DEPTH(NUM_SYMBOLS)) u_code_ram (
    .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
    .re(code_re), .raddr(code_raddr), .rdata_r(code_rdata)
  );

  hsc_ram #(.WIDTH(NODE_W), .DEPTH(DECODER_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .re(node_re), .raddr(node_raddr), .rdata_r(node_rdata)
  );

  assign rd_c0  = node_rdata[NODE_W-1 -: NA];
  assign rd_c1  = node_rdata[SYM_W +: NA];
  assign rd_sym = node_rdata[SYM_W-1:0];

  assign sym_ok      = {1'b0, sym_r} < (SYM_W+1)'(NUM_SYMBOLS);
  assign len_ok      = clen_r <= LEN_W'(MAX_CODE_LEN);
  assign last_sym    = cnt_r == NA'(NUM_SYMBOLS - 1);
  assign asg_match   = len_rdata == len_cur_r;
  assign cursor_full = cursor_r >= CUR_W'(DECODER_NODES);

  assign enc_bit     = (enc_j_r < LEN_W'(8)) ? enc_code_r[enc_j_r[2:0]] : 1'b0;
  assign cache_shift = {cache_r[6:0], enc_bit};
  assign fill_inc    = fill_r + FILL_W'(1);
  assign flush_val   = cache_r << (FILL_W'(BYTE_W) - fill_r);

  assign len_mask    = ~(8'hFF << len_cur_r[2:0]);
  assign sl_mask     = 8'(~(9'h1FF << sl_r));
  assign asg_b       = (len_cur_r < LEN_W'(8)) ? (bits_r & len_mask) : bits_r;
  assign rem_total   = len_cur_r - LEN_W'(sl_r);
  assign asg_prefix  = (rem_total >= LEN_W'(8)) ? 8'h00 : ((asg_b >> rem_total[2:0]) & sl_mask);

  assign rem_m1      = ins_rem_r - LEN_W'(1);
  assign ins_t       = (rem_m1 < LEN_W'(8)) ? ins_b_r[rem_m1[2:0]] : 1'b0;
  assign ins_child   = ins_t ? rd_c1 : rd_c0;

  assign dec_bit     = dbyte_r[dec_i_r];
  assign pa_new      = {pa_r[6:0], dec_bit};
  assign pc_inc      = pc_r + SL_W'(1);
  assign prefix_more = !walking_r && (pc_inc < sl_r);

  assign out_free = !out_v_r || out_ch.ready;
  assign can_emit = !pend_v_r || out_free;
  assign stall    = emit_req && !can_emit;

  assign in_ch.ready       = state_r == S_IDLE;
  assign out_ch.valid      = out_v_r;
  assign out_ch.out_kind   = out_r.kind;
  assign out_ch.out_value  = out_r.value;
  assign out_ch.error_code = out_r.err;
  assign out_ch.last       = out_last_r;

  always_comb begin
    emit_req       = 1'b0;
    emit_res.kind  = KIND_BYTE;
    emit_res.value = '0;
    emit_res.err   = ERR_NONE;
    case (state_r)
      S_CMD: begin
        case (func_r)
          FN_LOAD: begin
            if (!len_ok) begin
              emit_req      = 1'b1;
              emit_res.kind = KIND_ERR;
              emit_res.err  = ERR_TOO_LONG;
            end
          end
          FN_ENCODE: begin
            if (!sym_ok) begin
              emit_req      = 1'b1;
              emit_res.kind = KIND_ERR;
              emit_res.err  = ERR_UNCODED;
            end
          end
          FN_DECODE: begin
            if (sl_r == '0) begin
              emit_req      = 1'b1;
              emit_res.kind = KIND_ERR;
              emit_res.err  = ERR_NO_DEC;
            end
          end
          FN_FLUSH: begin
            if (fill_r != '0) begin
              emit_req       = 1'b1;
              emit_res.value = flush_val;
            end
          end
          default: begin
          end
        endcase
      end
      S_ENC_CHK: begin
        if (len_rdata == '0) begin
          emit_req      = 1'b1;
          emit_res.kind = KIND_ERR;
          emit_res.err  = ERR_UNCODED;
        end
      end
      S_ENC_BIT: begin
        if (fill_inc == FILL_W'(8)) begin
          emit_req       = 1'b1;
          emit_res.value = cache_shift;
        end
      end
      S_DEC_CHK: begin
        if (rd_c0 == '0) begin
          emit_req       = 1'b1;
          emit_res.kind  = KIND_SYM;
          emit_res.value = rd_sym;
        end
      end
      S_BDONE: begin
        if (!dec_ok_r) begin
          emit_req      = 1'b1;
          emit_res.kind = KIND_ERR;
          emit_res.err  = ERR_TOO_LONG;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (cnt_r == NA'(DECODER_NODES - 1)) begin
          state_nxt = clr_len_r ? S_IDLE : S_SCAN;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (!stall) begin
          case (func_r)
            FN_BUILD:  state_nxt = S_CLR;
            FN_ENCODE: state_nxt = sym_ok ? S_ENC_CHK : S_FIN;
            FN_DECODE: state_nxt = (sl_r != '0) ? S_DEC_BIT : S_FIN;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (last_sym) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: state_nxt = S_BPREP;
      S_BPREP:    state_nxt = (mx_r == '0) ? S_FIN : S_ASG_RD;
      S_ASG_RD:   state_nxt = S_ASG_EV;
      S_ASG_EV:   state_nxt = (asg_match && dec_ok_r) ? S_INS_RD : S_ASG_NXT;
      S_ASG_NXT: begin
        if (last_sym && len_cur_r == mn_r) begin
          state_nxt = S_BDONE;
        end else begin
          state_nxt = S_ASG_RD;
        end
      end
      S_INS_RD: state_nxt = S_INS_EV;
      S_INS_EV: begin
        if (ins_rem_r == '0 || (ins_child == '0 && cursor_full)) begin
          state_nxt = S_ASG_NXT;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_BDONE: begin
        if (!stall) begin
          state_nxt = S_FIN;
        end
      end
      S_ENC_CHK: begin
        if (!stall) begin
          state_nxt = (len_rdata == '0) ? S_FIN : S_ENC_BIT;
        end
      end
      S_ENC_BIT: begin
        if (!stall && enc_j_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_DEC_BIT: begin
        if (!prefix_more) begin
          state_nxt = S_DEC_CHK;
        end else if (dec_i_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_DEC_CHK: begin
        if (!stall) begin
          state_nxt = (dec_i_r == '0) ? S_FIN : S_DEC_BIT;
        end
      end
      S_FIN: begin
        if (!pend_v_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    clr_len_nxt  = clr_len_r;
    sl_nxt       = sl_r;
    mn_nxt       = mn_r;
    mx_nxt       = mx_r;
    dec_ok_nxt   = dec_ok_r;
    len_cur_nxt  = len_cur_r;
    bits_nxt     = bits_r;
    cursor_nxt   = cursor_r;
    ins_pos_nxt  = ins_pos_r;
    ins_rem_nxt  = ins_rem_r;
    ins_b_nxt    = ins_b_r;
    ins_sym_nxt  = ins_sym_r;
    enc_j_nxt    = enc_j_r;
    enc_code_nxt = enc_code_r;
    cache_nxt    = cache_r;
    fill_nxt     = fill_r;
    dec_i_nxt    = dec_i_r;
    pa_nxt       = pa_r;
    pc_nxt       = pc_r;
    walking_nxt  = walking_r;
    cur_c0_nxt   = cur_c0_r;
    cur_c1_nxt   = cur_c1_r;
    scan_v_nxt   = state_r == S_SCAN;

    len_we     = 1'b0;
    len_waddr  = '0;
    len_wdata  = '0;
    len_re     = 1'b0;
    len_raddr  = '0;
    code_we    = 1'b0;
    code_waddr = '0;
    code_wdata = '0;
    code_re    = 1'b0;
    code_raddr = '0;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = '0;

    if (scan_v_r) begin
      if (len_rdata != '0 && len_rdata < mn_r) begin
        mn_nxt = len_rdata;
      end
      if (len_rdata > mx_r) begin
        mx_nxt = len_rdata;
      end
    end

    case (state_r)
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = cnt_r;
        if ({1'b0, cnt_r} < (NA+1)'(NUM_SYMBOLS)) begin
          code_we    = 1'b1;
          code_waddr = cnt_r[SA-1:0];
          len_we     = clr_len_r;
          len_waddr  = cnt_r[SA-1:0];
        end
        cnt_nxt = (cnt_r == NA'(DECODER_NODES - 1)) ? '0 : cnt_r + NA'(1);
      end
      S_CMD: begin
        if (!stall) begin
          case (func_r)
            FN_LOAD: begin
              if (len_ok && sym_ok) begin
                len_we    = 1'b1;
                len_waddr = sym_r[SA-1:0];
                len_wdata = clen_r;
              end
            end
            FN_BUILD: begin
              cnt_nxt     = '0;
              clr_len_nxt = 1'b0;
              sl_nxt      = '0;
              pa_nxt      = '0;
              pc_nxt      = '0;
              walking_nxt = 1'b0;
              mn_nxt      = '1;
              mx_nxt      = '0;
            end
            FN_ENCODE: begin
              if (sym_ok) begin
                len_re     = 1'b1;
                len_raddr  = sym_r[SA-1:0];
                code_re    = 1'b1;
                code_raddr = sym_r[SA-1:0];
              end
            end
            FN_DECODE: dec_i_nxt = '1;
            FN_FLUSH: begin
              cache_nxt = '0;
              fill_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        len_re    = 1'b1;
        len_raddr = cnt_r[SA-1:0];
        cnt_nxt   = last_sym ? '0 : cnt_r + NA'(1);
      end
      S_BPREP: begin
        dec_ok_nxt  = mn_r <= LEN_W'(8);
        if (mn_r <= LEN_W'(8)) begin
          sl_nxt     = mn_r[SL_W-1:0];
          cursor_nxt = CUR_W'(1) << mn_r;
        end
        len_cur_nxt = mx_r;
        bits_nxt    = '0;
        cnt_nxt     = '0;
      end
      S_ASG_RD: begin
        len_re    = 1'b1;
        len_raddr = cnt_r[SA-1:0];
      end
      S_ASG_EV: begin
        if (asg_match) begin
          code_we     = 1'b1;
          code_waddr  = cnt_r[SA-1:0];
          code_wdata  = bits_r;
          bits_nxt    = bits_r + 8'd1;
          ins_b_nxt   = asg_b;
          ins_sym_nxt = SYM_W'(cnt_r);
          ins_pos_nxt = NA'(asg_prefix);
          ins_rem_nxt = rem_total;
        end
      end
      S_ASG_NXT: begin
        if (last_sym) begin
          bits_nxt = bits_r >> 1;
          cnt_nxt  = '0;
          if (len_cur_r != mn_r) begin
            len_cur_nxt = len_cur_r - LEN_W'(1);
          end
        end else begin
          cnt_nxt = cnt_r + NA'(1);
        end
      end
      S_INS_RD: begin
        node_re    = 1'b1;
        node_raddr = ins_pos_r;
      end
      S_INS_EV: begin
        node_waddr = ins_pos_r;
        if (ins_rem_r == '0) begin
          node_we    = 1'b1;
          node_wdata = {rd_c0, rd_c1, ins_sym_r};
        end else if (ins_child == '0) begin
          if (!cursor_full) begin
            node_we     = 1'b1;
            node_wdata  = ins_t ? {rd_c0, cursor_r[NA-1:0], rd_sym}
                                : {cursor_r[NA-1:0], rd_c1, rd_sym};
            ins_pos_nxt = cursor_r[NA-1:0];
            cursor_nxt  = cursor_r + CUR_W'(1);
            ins_rem_nxt = rem_m1;
          end
        end else begin
          ins_pos_nxt = ins_child;
          ins_rem_nxt = rem_m1;
        end
      end
      S_ENC_CHK: begin
        if (!stall && len_rdata != '0) begin
          enc_j_nxt    = len_rdata - LEN_W'(1);
          enc_code_nxt = code_rdata;
        end
      end
      S_ENC_BIT: begin
        if (!stall) begin
          if (fill_inc == FILL_W'(8)) begin
            cache_nxt = '0;
            fill_nxt  = '0;
          end else begin
            cache_nxt = cache_shift;
            fill_nxt  = fill_inc;
          end
          if (enc_j_r != '0) begin
            enc_j_nxt = enc_j_r - LEN_W'(1);
          end
        end
      end
      S_DEC_BIT: begin
        if (walking_r) begin
          node_re    = 1'b1;
          node_raddr = dec_bit ? cur_c1_r : cur_c0_r;
        end else if (prefix_more) begin
          pa_nxt = pa_new;
          pc_nxt = pc_inc;
          if (dec_i_r != '0) begin
            dec_i_nxt = dec_i_r - BIDX_W'(1);
          end
        end else begin
          node_re    = 1'b1;
          node_raddr = NA'(pa_new & sl_mask);
          pa_nxt     = '0;
          pc_nxt     = '0;
        end
      end
      S_DEC_CHK: begin
        if (!stall) begin
          if (rd_c0 == '0) begin
            walking_nxt = 1'b0;
          end else begin
            walking_nxt = 1'b1;
            cur_c0_nxt  = rd_c0;
            cur_c1_nxt  = rd_c1;
          end
          if (dec_i_r != '0) begin
            dec_i_nxt = dec_i_r - BIDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    if (emit_req && can_emit) begin
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = emit_res;
    end
    if (state_r == S_FIN && pend_v_r && out_free) begin
      out_v_nxt    = 1'b1;
      out_nxt      = pend_r;
      out_last_nxt = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cnt_r     <= '0;
      clr_len_r <= 1'b1;
      sl_r      <= '0;
      scan_v_r  <= 1'b0;
      cache_r   <= '0;
      fill_r    <= '0;
      pa_r      <= '0;
      pc_r      <= '0;
      walking_r <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      clr_len_r <= clr_len_nxt;
      sl_r      <= sl_nxt;
      scan_v_r  <= scan_v_nxt;
      cache_r   <= cache_nxt;
      fill_r    <= fill_nxt;
      pa_r      <= pa_nxt;
      pc_r      <= pc_nxt;
      walking_r <= walking_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r  <= in_ch.func;
      sym_r   <= in_ch.symbol;
      clen_r  <= in_ch.code_length;
      dbyte_r <= in_ch.data_byte;
    end
    mn_r       <= mn_nxt;
    mx_r       <= mx_nxt;
    dec_ok_r   <= dec_ok_nxt;
    len_cur_r  <= len_cur_nxt;
    bits_r     <= bits_nxt;
    cursor_r   <= cursor_nxt;
    ins_pos_r  <= ins_pos_nxt;
    ins_rem_r  <= ins_rem_nxt;
    ins_b_r    <= ins_b_nxt;
    ins_sym_r  <= ins_sym_nxt;
    enc_j_r    <= enc_j_nxt;
    enc_code_r <= enc_code_nxt;
    dec_i_r    <= dec_i_nxt;
    cur_c0_r   <= cur_c0_nxt;
    cur_c1_r   <= cur_c1_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: sv/hsc_checker.sv
`timescale 1ns / 1ps
module hsc_checker (
  input logic       clk,
  input logic       rst_n,
  hsc_in_if.sink    in_ch,
  hsc_out_if.source out_ch
);
  import hsc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("Result dropped while the receiver stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.out_value) && $stable(out_ch.out_kind)
      && $stable(out_ch.error_code) && $stable(out_ch.last))
    else $error("Result changed while the receiver stalled.");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("A second command was taken while one was in progress.");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.out_kind == KIND_BYTE || out_ch.out_kind == KIND_SYM
      || out_ch.out_kind == KIND_ERR)
      && ((out_ch.out_kind == KIND_ERR) == (out_ch.error_code != ERR_NONE))
      && (out_ch.out_kind != KIND_ERR || out_ch.out_value == '0))
    else $error("Result kind and error code disagree.");

endmodule

bind huffman_stream_codec hsc_checker u_hsc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ch(in_ch),
  .out_ch(out_ch)
);
